@@ sv/arm_enc_pkg.sv @@
// ----------------------------------------------------------------------------
// arm_enc_pkg
// Shared types and constants for the ARM-style instruction word encoder.
// ----------------------------------------------------------------------------
package arm_enc_pkg;

    typedef logic [5:0]  op_t;
    typedef logic [3:0]  reg_num_t;
    typedef logic [31:0] word_t;

    localparam int CNT_W       = 24;   // instruction counter width (branch offsets use BRANCH_BITS)
    localparam int BRANCH_BITS = 24;
    localparam int PC_AHEAD    = 2;
    localparam logic [3:0] MUL_MARK = 4'd9;

    typedef logic [CNT_W-1:0] cnt_t;

    // instruction kinds
    localparam op_t OP_TST      = 6'd8;
    localparam op_t OP_CMN      = 6'd11;
    localparam op_t OP_ORR      = 6'd12;
    localparam op_t OP_LSL      = 6'd14;
    localparam op_t OP_LSR      = 6'd15;
    localparam op_t OP_ASR      = 6'd16;
    localparam op_t OP_RRX      = 6'd17;
    localparam op_t OP_ROR      = 6'd18;
    localparam op_t OP_BIC      = 6'd19;
    localparam op_t OP_DP_LAST  = 6'd20;
    localparam op_t OP_MUL_LAST = 6'd26;
    localparam op_t OP_STR      = 6'd27;
    localparam op_t OP_LDR      = 6'd28;
    localparam op_t OP_STRB     = 6'd29;
    localparam op_t OP_LDRB     = 6'd30;
    localparam op_t OP_STRH     = 6'd31;
    localparam op_t OP_LDRH     = 6'd32;
    localparam op_t OP_LDRSB    = 6'd33;
    localparam op_t OP_LDRSH    = 6'd34;
    localparam op_t OP_B        = 6'd35;
    localparam op_t OP_BL       = 6'd36;

    // data-processing opcode field values for the folded ops
    localparam logic [3:0] DPC_MOV = 4'd13;
    localparam logic [3:0] DPC_BIC = 4'd14;
    localparam logic [3:0] DPC_MVN = 4'd15;

    // shift slot codes
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // halfword transfer S:H codes
    localparam logic [1:0] HW_UHALF = 2'd1;
    localparam logic [1:0] HW_SBYTE = 2'd2;
    localparam logic [1:0] HW_SHALF = 2'd3;

    // second operand forms
    localparam logic [1:0] FORM_IMM     = 2'd0;
    localparam logic [1:0] FORM_REG_IMM = 2'd1;
    localparam logic [1:0] FORM_REG_REG = 2'd2;
    localparam logic [1:0] FORM_BAD     = 2'd3;

    // index modes
    localparam logic [1:0] IDX_POST   = 2'd0;
    localparam logic [1:0] IDX_OFFSET = 2'd1;
    localparam logic [1:0] IDX_PRE    = 2'd2;
    localparam logic [1:0] IDX_OTHER  = 2'd3;

    localparam logic [3:0] COND_NV = 4'd15;

    typedef struct packed {
        op_t         op;
        logic [3:0]  condition;
        logic [1:0]  operand_form;
        logic        set_flags;
        reg_num_t    first_reg;
        reg_num_t    dest_reg;
        reg_num_t    second_reg;
        reg_num_t    shift_reg;
        logic [23:0] immediate;
        logic [1:0]  shift_kind;
        logic [1:0]  index_mode;
        logic        add_offset;
    } item_t;

endpackage

@@ sv/arm_instruction_word_encoder.sv @@
// ----------------------------------------------------------------------------
// arm_instruction_word_encoder
// Packs one parsed instruction per item into a 32-bit ARM-style word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | op .. add_offset (12 fields)
//  m_      | out       | m_valid / m_ready  | machine_word (32 bits)
//
// Two registers: the input register and the result register, with the
// encoder logic in between. One item per cycle is sustained while m_ready stays high.
// The 24-bit instruction counter is sampled with each accepted item and
// advances by one per item. Reset (aresetn low, synchronous) empties both
// stages and zeroes the counter. A stall on m_ready backs up through the
// result register into the input register, then drops s_ready.
module arm_instruction_word_encoder
    import arm_enc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [5:0]  s_op,
    input  logic [3:0]  s_condition,
    input  logic [1:0]  s_operand_form,
    input  logic        s_set_flags,
    input  logic [3:0]  s_first_reg,
    input  logic [3:0]  s_dest_reg,
    input  logic [3:0]  s_second_reg,
    input  logic [3:0]  s_shift_reg,
    input  logic [23:0] s_immediate,
    input  logic [1:0]  s_shift_kind,
    input  logic [1:0]  s_index_mode,
    input  logic        s_add_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_machine_word
);

    item_t item_reg;
    cnt_t  idx_reg;
    cnt_t  cnt_reg, cnt_next;
    logic  in_valid_reg;
    logic  out_valid_reg;
    word_t word_reg, word_next;
    logic  in_accept;
    logic  out_load;

    assign out_load  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || out_load;
    assign in_accept = s_valid && s_ready;
    assign cnt_next  = cnt_reg + cnt_t'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (s_ready)
                in_valid_reg <= s_valid;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
            if (in_accept)
                cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            item_reg <= '{op: s_op, condition: s_condition, operand_form: s_operand_form,
                          set_flags: s_set_flags, first_reg: s_first_reg,
                          dest_reg: s_dest_reg, second_reg: s_second_reg,
                          shift_reg: s_shift_reg, immediate: s_immediate,
                          shift_kind: s_shift_kind, index_mode: s_index_mode,
                          add_offset: s_add_offset};
            idx_reg  <= cnt_reg;
        end
        if (out_load)
            word_reg <= word_next;
    end

    // encoder
    logic [3:0]             cond;
    logic [3:0]             dp_opc;
    logic                   s_bit;
    logic [1:0]             sh;
    logic [1:0]             sh2;
    logic                   p_bit;
    logic                   w_bit;
    logic [BRANCH_BITS-1:0] offset;

    always_comb begin
        cond = (item_reg.condition == COND_NV) ? 4'd0 : item_reg.condition;

        if (item_reg.op <= OP_ORR)
            dp_opc = item_reg.op[3:0];
        else if (item_reg.op <= OP_ROR)
            dp_opc = DPC_MOV;
        else if (item_reg.op == OP_BIC)
            dp_opc = DPC_BIC;
        else
            dp_opc = DPC_MVN;

        s_bit = item_reg.set_flags || (item_reg.op >= OP_TST && item_reg.op <= OP_CMN);

        // shift-named ops override the slot code (LSL: SH_LSR, ASR: SH_ASR, LSR/RRX: SH_ROR); others use shift_kind
        case (item_reg.op)
            OP_LSL:         sh = SH_LSR;
            OP_ASR:         sh = SH_ASR;
            OP_LSR, OP_RRX: sh = SH_ROR;
            default:        sh = item_reg.shift_kind;
        endcase

        case (item_reg.op)
            OP_STRH, OP_LDRH: sh2 = HW_UHALF;
            OP_LDRSB:         sh2 = HW_SBYTE;
            default:          sh2 = HW_SHALF;
        endcase

        p_bit = item_reg.index_mode inside {IDX_OFFSET, IDX_PRE};
        w_bit = item_reg.index_mode inside {IDX_PRE, IDX_OTHER};

        offset = item_reg.immediate[BRANCH_BITS-1:0]
                 - (idx_reg[BRANCH_BITS-1:0] + BRANCH_BITS'(PC_AHEAD));

        word_next = '0;
        if (item_reg.op <= OP_DP_LAST) begin
            if (item_reg.operand_form != FORM_BAD) begin
                word_next[31:28] = cond;
                word_next[25]    = (item_reg.operand_form == FORM_IMM);
                word_next[24:21] = dp_opc;
                word_next[20]    = s_bit;
                word_next[19:16] = item_reg.first_reg;
                word_next[15:12] = item_reg.dest_reg;
                if (item_reg.operand_form == FORM_IMM) begin
                    word_next[11:0] = item_reg.immediate[11:0];
                end else begin
                    word_next[6:5] = sh;
                    word_next[3:0] = item_reg.second_reg;
                    // RRX drops the amount / Rs and the register-shift bit
                    if (item_reg.op != OP_RRX) begin
                        if (item_reg.operand_form == FORM_REG_IMM) begin
                            word_next[11:7] = item_reg.immediate[4:0];
                        end else begin
                            word_next[11:8] = item_reg.shift_reg;
                            word_next[4]    = 1'b1;
                        end
                    end
                end
            end
        end else if (item_reg.op <= OP_MUL_LAST) begin
            word_next[31:28] = cond;
            word_next[20]    = item_reg.set_flags;
            word_next[19:16] = item_reg.dest_reg;
            word_next[15:12] = item_reg.shift_reg;
            word_next[11:8]  = item_reg.second_reg;
            word_next[7:4]   = MUL_MARK;
            word_next[3:0]   = item_reg.first_reg;
        end else if (item_reg.op <= OP_LDRSH) begin
            word_next[31:28] = cond;
            word_next[24]    = p_bit;
            word_next[23]    = item_reg.add_offset;
            word_next[21]    = w_bit;
            word_next[19:16] = item_reg.first_reg;
            word_next[15:12] = item_reg.dest_reg;
            if (item_reg.op <= OP_LDRB) begin
                word_next[26] = 1'b1;
                word_next[22] = item_reg.op inside {OP_STRB, OP_LDRB};
                word_next[20] = item_reg.op inside {OP_LDR, OP_LDRB};
                if (item_reg.operand_form == FORM_IMM) begin
                    word_next[11:0] = item_reg.immediate[11:0];
                end else begin
                    word_next[25]   = 1'b1;
                    word_next[11:7] = item_reg.immediate[4:0];
                    word_next[6:5]  = item_reg.shift_kind;
                    word_next[4]    = 1'b1;
                    word_next[3:0]  = item_reg.second_reg;
                end
            end else begin
                word_next[20]  = (item_reg.op != OP_STRH);
                word_next[7]   = 1'b1;
                word_next[6:5] = sh2;
                word_next[4]   = 1'b1;
                if (item_reg.operand_form == FORM_IMM) begin
                    word_next[22]   = 1'b1;
                    word_next[11:8] = item_reg.immediate[7:4];
                    word_next[3:0]  = item_reg.immediate[3:0];
                end else begin
                    word_next[3:0]  = item_reg.second_reg;
                end
            end
        end else if (item_reg.op <= OP_BL) begin
            word_next[31:28] = cond;
            word_next[27:25] = 3'b101;
            word_next[24]    = (item_reg.op == OP_BL);
            word_next[BRANCH_BITS-1:0] = offset;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_machine_word = word_reg;

endmodule

@@ sv/arm_enc_checker.sv @@
// ----------------------------------------------------------------------------
// arm_enc_checker
// Port-level checks for the instruction word encoder, bound to the top level.
// ----------------------------------------------------------------------------
module arm_enc_checker
    import arm_enc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_machine_word
);

    // items accepted but not yet delivered; the block holds at most two
    logic [1:0] inflight_reg, inflight_next;

    always_comb begin
        inflight_next = inflight_reg;
        if (s_valid && s_ready && !(m_valid && m_ready))
            inflight_next = inflight_reg + 2'd1;
        else if (!(s_valid && s_ready) && m_valid && m_ready)
            inflight_next = inflight_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_machine_word))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg != 2'd3 && (!m_valid || inflight_reg != 2'd0))
        else $error("item count out of range");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == 2'd2 && !m_ready |-> !s_ready)
        else $error("item taken while both stages full");

    a_cond_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_machine_word[31:28] != COND_NV)
        else $error("condition fifteen in result");

endmodule

bind arm_instruction_word_encoder arm_enc_checker u_arm_enc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_machine_word (m_machine_word)
);
